[rtl/core/tactile_frame_unpacker_top_assert.svh]
// Assertion macros shared by the tactile frame unpacker RTL.
`ifndef TACTILE_FRAME_UNPACKER_TOP_ASSERT_SVH
`define TACTILE_FRAME_UNPACKER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk and masked during reset.
`define TFU_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and masked during reset.
`define TFU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/tfu_pkg.sv]
// Shared types and constants for the tactile frame unpacker.
package tfu_pkg;

  localparam int CELL_COUNT      = 24;
  localparam int SEQ_COUNT       = 5;
  localparam int CELLS_PER_FRAME = 5;
  localparam int FRAME_BYTES     = 8;
  localparam int QUEUE_DEPTH     = 2;

  localparam int KIND_W  = 1;
  localparam int DATA_W  = 64;
  localparam int LEN_W   = 4;
  localparam int CELL_W  = 5;
  localparam int VALUE_W = 12;
  localparam int STAT_W  = 2;
  localparam int NIB_W   = 4;
  localparam int MAP_W   = 24;
  localparam int BITS_W  = 60;
  localparam int LEVEL_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [KIND_W-1:0] KIND_FULL = 1'b0;
  localparam logic [KIND_W-1:0] KIND_TOP  = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_OK  = 2'd0,
    ST_LEN = 2'd1,
    ST_SEQ = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CMD_ERR  = 2'd0,
    CMD_FULL = 2'd1,
    CMD_TOP  = 2'd2
  } cmd_kind_t;

  // One classified frame, as handed from the front end to the back end.
  typedef struct packed {
    cmd_kind_t          kind;
    status_t            status;
    logic [CELL_W-1:0]  first;
    logic [CELL_W-1:0]  last_step;
    logic [MAP_W-1:0]   map;
    logic [BITS_W-1:0]  bits;
  } cmd_t;

  typedef struct packed {
    logic               full;
    logic [LEVEL_W-1:0] level;
  } q_stat_t;

endpackage

[rtl/core/tfu_if.sv]
// Valid/ready channel interfaces for frame requests and cell results.
interface tfu_in_if;
  logic                        valid;
  logic                        ready;
  logic [tfu_pkg::KIND_W-1:0]  kind;
  logic [tfu_pkg::DATA_W-1:0]  frame_data;
  logic [tfu_pkg::LEN_W-1:0]   frame_length;

  modport source (output valid, kind, frame_data, frame_length, input ready);
  modport sink   (input valid, kind, frame_data, frame_length, output ready);
endinterface

interface tfu_out_if;
  logic                        valid;
  logic                        ready;
  logic [tfu_pkg::CELL_W-1:0]  cell_index;
  logic [tfu_pkg::VALUE_W-1:0] cell_value;
  logic [tfu_pkg::STAT_W-1:0]  status;
  logic                        last;

  modport source (output valid, cell_index, cell_value, status, last, input ready);
  modport sink   (input valid, cell_index, cell_value, status, last, output ready);
endinterface

[rtl/core/tfu_front.sv]
// Front end: accepts frame requests and classifies them into commands.
module tfu_front (
  tfu_in_if.sink        in_ch,
  input  tfu_pkg::q_stat_t q_stat,
  output logic          push,
  output tfu_pkg::cmd_t push_cmd
);
  import tfu_pkg::*;

  logic [NIB_W-1:0]  seq;
  logic [CELL_W:0]   first_w;
  logic [CELL_W:0]   end_w;

  assign in_ch.ready = !q_stat.full;
  assign push        = in_ch.valid && in_ch.ready;

  assign seq     = in_ch.frame_data[DATA_W-1 -: NIB_W];
  // Five cells per sequence number: seq*4 + seq.
  assign first_w = {seq[2:0], 2'b00} + {3'b000, seq[2:0]};
  assign end_w   = first_w + (CELL_W+1)'(CELLS_PER_FRAME);

  always_comb begin
    push_cmd        = '0;
    push_cmd.kind   = CMD_ERR;
    push_cmd.status = ST_OK;
    if (in_ch.frame_length != LEN_W'(FRAME_BYTES)) begin
      push_cmd.status = ST_LEN;
    end else if (in_ch.kind == KIND_FULL) begin
      if (seq >= NIB_W'(SEQ_COUNT)) begin
        push_cmd.status = ST_SEQ;
      end else begin
        push_cmd.kind  = CMD_FULL;
        push_cmd.first = first_w[CELL_W-1:0];
        push_cmd.bits  = in_ch.frame_data[BITS_W-1:0];
        // The last frame covers fewer cells than the others.
        if (end_w > (CELL_W+1)'(CELL_COUNT)) begin
          push_cmd.last_step = CELL_W'(CELL_COUNT - 1) - first_w[CELL_W-1:0];
        end else begin
          push_cmd.last_step = CELL_W'(CELLS_PER_FRAME - 1);
        end
      end
    end else begin
      push_cmd.kind      = CMD_TOP;
      push_cmd.last_step = CELL_W'(CELL_COUNT - 1);
      push_cmd.map       = in_ch.frame_data[DATA_W-1 -: MAP_W];
      // Ten nibbles packed at the top; zeros shift in once they run out.
      push_cmd.bits      = {in_ch.frame_data[DATA_W-MAP_W-1:0],
                            (BITS_W-(DATA_W-MAP_W))'(0)};
    end
  end

endmodule

[rtl/core/tfu_queue.sv]
// Short command queue between the front end and the back end.
module tfu_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  tfu_pkg::cmd_t    push_cmd,
  input  logic             pop,
  output logic             q_valid,
  output tfu_pkg::cmd_t    q_cmd,
  output tfu_pkg::q_stat_t q_stat
);
  import tfu_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  cmd_t               mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [LEVEL_W-1:0] level_r, level_nxt;

  assign q_valid      = (level_r != '0);
  assign q_cmd        = mem_r[rd_ptr_r];
  assign q_stat.full  = (level_r == LEVEL_W'(QUEUE_DEPTH));
  assign q_stat.level = level_r;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop  ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    level_nxt  = level_r + LEVEL_W'(push) - LEVEL_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

[rtl/core/tfu_back.sv]
// Back end: steps through one command per frame and emits cell results.
module tfu_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  tfu_pkg::cmd_t q_cmd,
  output logic          pop,
  tfu_out_if.source     out_ch
);
  import tfu_pkg::*;

  logic               busy_r, busy_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic [CELL_W-1:0]  step_r, step_nxt;
  logic [MAP_W-1:0]   map_r, map_nxt;
  logic [BITS_W-1:0]  sh_r, sh_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [CELL_W-1:0]  out_cell_r, out_cell_nxt;
  logic [VALUE_W-1:0] out_value_r, out_value_nxt;
  logic [STAT_W-1:0]  out_status_r, out_status_nxt;
  logic               out_last_r, out_last_nxt;

  logic               advance;
  logic               final_step;

  assign advance    = busy_r && (!out_valid_r || out_ch.ready);
  assign final_step = (step_r == cmd_r.last_step);
  assign pop        = q_valid && (!busy_r || (advance && final_step));

  assign out_ch.valid      = out_valid_r;
  assign out_ch.cell_index = out_cell_r;
  assign out_ch.cell_value = out_value_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.last       = out_last_r;

  always_comb begin
    busy_nxt       = busy_r;
    cmd_nxt        = cmd_r;
    step_nxt       = step_r;
    map_nxt        = map_r;
    sh_nxt         = sh_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_cell_nxt   = out_cell_r;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;

    if (advance) begin
      out_valid_nxt  = 1'b1;
      out_cell_nxt   = cmd_r.first + step_r;
      out_status_nxt = cmd_r.status;
      out_last_nxt   = final_step;
      step_nxt       = step_r + CELL_W'(1);
      unique case (cmd_r.kind)
        CMD_FULL: begin
          out_value_nxt = sh_r[BITS_W-1 -: VALUE_W];
          sh_nxt        = sh_r << VALUE_W;
        end
        CMD_TOP: begin
          out_value_nxt = '0;
          if (map_r[0]) begin
            out_value_nxt = VALUE_W'(sh_r[BITS_W-1 -: NIB_W]);
            sh_nxt        = sh_r << NIB_W;
          end
          map_nxt = map_r >> 1;
        end
        default: begin
          out_value_nxt = '0;
        end
      endcase
      if (final_step) begin
        busy_nxt = 1'b0;
      end
    end

    if (pop) begin
      busy_nxt = 1'b1;
      cmd_nxt  = q_cmd;
      step_nxt = '0;
      map_nxt  = q_cmd.map;
      sh_nxt   = q_cmd.bits;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    step_r       <= step_nxt;
    map_r        <= map_nxt;
    sh_r         <= sh_nxt;
    out_cell_r   <= out_cell_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

endmodule

[rtl/core/tactile_frame_unpacker_top.sv]
// Tactile frame unpacker: frame requests in, per-cell result requests out.
// A frame's command is registered in the queue, then loaded into the back end, whose output is registered.
// Throughput: one result per cycle while the receiver is ready; a frame gives 1, 4, 5 or 24 results.
// Frames are taken every cycle while the two-entry command queue has room.
// Reset (rst_n low, synchronous) empties the queue, idles the back end and drops
// any pending result; there is no configuration state.
module tactile_frame_unpacker_top (
  input  logic      clk,
  input  logic      rst_n,
  tfu_in_if.sink    in_ch,
  tfu_out_if.source out_ch
);
  import tfu_pkg::*;

  `include "tactile_frame_unpacker_top_assert.svh"

  // Front end to queue: one classified command per accepted frame request.
  logic    push;
  cmd_t    push_cmd;
  q_stat_t q_stat;

  // Queue to back end: the oldest command, removed when the back end starts it.
  logic    q_valid;
  cmd_t    q_cmd;
  logic    pop;

  // The front end checks the length and sequence number and works out the
  // first cell and the number of steps, so the back end only counts and shifts.
  tfu_front u_front (
    .in_ch    (in_ch),
    .q_stat   (q_stat),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // The queue decouples the two sides: a new frame is taken while the back
  // end is still emitting the cells of an earlier one.
  tfu_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_stat   (q_stat)
  );

  // The back end emits one cell per cycle into a registered output stage while the
  // receiver keeps up; it starts the next command in the same cycle its last cell enters that stage.
  tfu_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .pop     (pop),
    .out_ch  (out_ch)
  );

  // An error result is always the single, final result of its frame.
  `TFU_ASSERT_SAME(a_err_single, out_ch.valid && (out_ch.status != ST_OK), out_ch.last && (out_ch.cell_index == '0) && (out_ch.cell_value == '0), "error result is not a lone cell-zero result")

  // Every result names a real sensor cell.
  `TFU_ASSERT_SAME(a_cell_range, out_ch.valid, out_ch.cell_index < CELL_W'(CELL_COUNT), "cell index out of range")

  // An accepted frame request must be held in the queue on the next cycle.
  `TFU_ASSERT_NEXT(a_push_kept, in_ch.valid && in_ch.ready, q_stat.level != '0, "accepted frame lost by the queue")

endmodule

[tb/tb_tactile_frame_unpacker_top.sv]
// Self-checking testbench for the tactile frame unpacker: directed table, then random frames.
module tb_tactile_frame_unpacker_top;
  import tfu_pkg::*;

  // Run shape. The long receiver hold opens the last phase so that the command
  // queue fills and frame requests back up at the input.
  localparam int PHASE_FRAMES   = 140;
  localparam int LONG_HOLD      = 400;
  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DIRECTED_COUNT = 18;
  localparam logic [LEN_W-1:0] LEN_OK = LEN_W'(FRAME_BYTES);

  // One cell update as it leaves the block.
  typedef struct packed {
    logic [CELL_W-1:0]  cell_idx;
    logic [VALUE_W-1:0] value;
    status_t            status;
    logic               last;
  } cell_result_t;

  // One row of the directed table. When typed is set, the frame must give
  // exactly the single result in res; otherwise the decoder below predicts it.
  typedef struct packed {
    logic               typed;
    logic [KIND_W-1:0]  kind;
    logic [LEN_W-1:0]   len;
    logic [DATA_W-1:0]  data;
    cell_result_t       res;
  } frame_row_t;

  localparam cell_result_t NO_RESULT = '{cell_idx: '0, value: '0, status: ST_OK, last: 1'b0};
  localparam cell_result_t ERR_LEN   = '{cell_idx: '0, value: '0, status: ST_LEN, last: 1'b1};
  localparam cell_result_t ERR_SEQ   = '{cell_idx: '0, value: '0, status: ST_SEQ, last: 1'b1};

  localparam frame_row_t DIRECTED_ROWS [0:DIRECTED_COUNT-1] = '{
    // Full format: every sequence number, zero codes, all-ones codes, and
    // single set bits at the code boundaries.
    '{1'b0, KIND_FULL, LEN_OK, 64'h0000_0000_0000_0000, NO_RESULT},
    '{1'b0, KIND_FULL, LEN_OK, 64'h0FFF_FFFF_FFFF_FFFF, NO_RESULT},
    '{1'b0, KIND_FULL, LEN_OK, 64'h1123_4567_89AB_CDEF, NO_RESULT},
    '{1'b0, KIND_FULL, LEN_OK, 64'h2800_8008_0080_0800, NO_RESULT},
    '{1'b0, KIND_FULL, LEN_OK, 64'h3FED_CBA9_8765_4321, NO_RESULT},
    // Sequence four covers cells 20 to 23; its fifth code has no cell.
    '{1'b0, KIND_FULL, LEN_OK, 64'h4ABC_DEF0_1234_5678, NO_RESULT},
    // Sequence numbers past four are rejected.
    '{1'b1, KIND_FULL, LEN_OK, 64'h5000_0000_0000_0000, ERR_SEQ},
    '{1'b1, KIND_FULL, LEN_OK, 64'hFFFF_FFFF_FFFF_FFFF, ERR_SEQ},
    // Top-ten format: empty map, full map with more cells than nibbles,
    // cells 0 and 23 alone, exactly ten cells, and a full map of zero nibbles.
    '{1'b0, KIND_TOP,  LEN_OK, 64'h0000_0000_0000_0000, NO_RESULT},
    '{1'b0, KIND_TOP,  LEN_OK, 64'hFFFF_FF12_3456_789A, NO_RESULT},
    '{1'b0, KIND_TOP,  LEN_OK, 64'hFFFF_FFFF_FFFF_FFFF, NO_RESULT},
    '{1'b0, KIND_TOP,  LEN_OK, 64'h8000_01F0_0000_000F, NO_RESULT},
    '{1'b0, KIND_TOP,  LEN_OK, 64'h0003_FF5A_5A5A_5A5A, NO_RESULT},
    '{1'b0, KIND_TOP,  LEN_OK, 64'hFFFF_FF00_0000_0000, NO_RESULT},
    // Wrong lengths win over everything else, a bad sequence number included.
    '{1'b1, KIND_FULL, 4'd0,   64'h0000_0000_0000_0000, ERR_LEN},
    '{1'b1, KIND_TOP,  4'd15,  64'hFFFF_FFFF_FFFF_FFFF, ERR_LEN},
    '{1'b1, KIND_FULL, 4'd7,   64'hF000_0000_0000_0000, ERR_LEN},
    '{1'b1, KIND_TOP,  4'd9,   64'h0000_0000_0000_1234, ERR_LEN}
  };

  logic clk;
  logic rst_n;

  tfu_in_if  in_bus ();
  tfu_out_if out_bus ();

  tactile_frame_unpacker_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  // Expected cell updates, oldest first.
  cell_result_t pending_cells [$];

  // Side information that travels with the frame request on offer.
  logic         offer_typed;
  cell_result_t offer_res;

  int tx_idle_pct;
  int rx_idle_pct;
  logic hold_go;
  logic hold_taken;
  int hold_cnt;
  int quiet_cycles;

  int mismatches;
  int frames_sent;
  int full_frames;
  int top_frames;
  int rejected_frames;
  int results_checked;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Prints one line per bad field and keeps the count for the final verdict.
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at %0t: %s got %0d expected %0d (result %0d)",
             $time, what, got, want, results_checked);
    mismatches++;
  endtask

  function automatic void push_cell(input int cell_no, input logic [VALUE_W-1:0] value,
                                    input status_t status, input logic last);
    cell_result_t r;
    r.cell_idx = CELL_W'(cell_no);
    r.value    = value;
    r.status   = status;
    r.last     = last;
    pending_cells.push_back(r);
  endfunction

  // Decodes one accepted frame into the cell updates it must produce.
  function automatic void unpack_frame(input logic [KIND_W-1:0] kind,
                                       input logic [DATA_W-1:0] data,
                                       input logic [LEN_W-1:0] len);
    logic [3:0]       seq;
    logic [MAP_W-1:0] map;
    logic [VALUE_W-1:0] value;
    int first;
    int used;
    if (len != LEN_OK) begin
      push_cell(0, '0, ST_LEN, 1'b1);
      return;
    end
    if (kind == KIND_FULL) begin
      seq = data[63:60];
      if (seq >= SEQ_COUNT) begin
        push_cell(0, '0, ST_SEQ, 1'b1);
        return;
      end
      first = seq * CELLS_PER_FRAME;
      // Codes sit below the sequence nibble, most significant first.
      for (int j = 0; j < CELLS_PER_FRAME; j++) begin
        if (first + j >= CELL_COUNT) break;
        push_cell(first + j, data[(48 - 12 * j) +: VALUE_W], ST_OK, 1'b0);
      end
    end else begin
      map  = data[63:40];
      used = 0;
      // Mapped cells take nibbles from the low 40 bits in order; once the
      // ten nibbles are spent they read zero, like unmapped cells.
      for (int c = 0; c < CELL_COUNT; c++) begin
        value = '0;
        if (map[c]) begin
          if (used < 10) value = VALUE_W'(data[(36 - 4 * used) +: NIB_W]);
          used++;
        end
        push_cell(c, value, ST_OK, 1'b0);
      end
    end
    pending_cells[pending_cells.size() - 1].last = 1'b1;
  endfunction

  // Offers one frame request after a random gap and returns once it is taken.
  // Valid is lowered only inside a gap, so back-to-back requests keep it high.
  task automatic send_frame(input logic [KIND_W-1:0] kind, input logic [DATA_W-1:0] data,
                            input logic [LEN_W-1:0] len, input logic typed,
                            input cell_result_t res);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.kind         <= kind;
    in_bus.frame_data   <= data;
    in_bus.frame_length <= len;
    offer_typed         <= typed;
    offer_res           <= res;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
  endtask

  // Random frames lean toward well-formed ones: a legal length and, in full
  // format, a legal sequence number. Maps range from sparse to nearly full.
  task automatic random_frame(output logic [KIND_W-1:0] kind, output logic [DATA_W-1:0] data,
                              output logic [LEN_W-1:0] len);
    logic [MAP_W-1:0] map;
    kind = KIND_W'($urandom_range(1));
    data = {$urandom, $urandom};
    len  = ($urandom_range(99) < 88) ? LEN_OK : LEN_W'($urandom_range(15));
    if (kind == KIND_FULL) begin
      if ($urandom_range(99) < 90) data[63:60] = 4'($urandom_range(SEQ_COUNT - 1));
      else data[63:60] = 4'($urandom_range(15, SEQ_COUNT));
    end else begin
      case ($urandom_range(3))
        0:       map = MAP_W'($urandom & $urandom & $urandom);
        1:       map = MAP_W'(~($urandom & $urandom));
        default: map = MAP_W'($urandom);
      endcase
      data[63:40] = map;
    end
  endtask

  task automatic run_random_phase(input int tx_pct, input int rx_pct);
    logic [KIND_W-1:0] kind;
    logic [DATA_W-1:0] data;
    logic [LEN_W-1:0]  len;
    tx_idle_pct = tx_pct;
    rx_idle_pct <= rx_pct;
    for (int i = 0; i < PHASE_FRAMES; i++) begin
      random_frame(kind, data, len);
      send_frame(kind, data, len, 1'b0, NO_RESULT);
    end
  endtask

  // The receiver owns the ready line. A single long hold is started on
  // request and counted down here; otherwise ready follows the idle mix.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      hold_cnt      <= 0;
      hold_taken    <= 1'b0;
    end else if (hold_go && !hold_taken) begin
      hold_taken    <= 1'b1;
      hold_cnt      <= LONG_HOLD;
      out_bus.ready <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt      <= hold_cnt - 1;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Checks each result request against the oldest expectation, then records
  // the expectations of a frame request taken at the same edge. The results
  // of a frame pass through the queue and back-end registers, so the order is safe.
  always @(posedge clk) begin
    cell_result_t got;
    cell_result_t want;
    if (rst_n) begin
      if (out_bus.valid && out_bus.ready) begin
        got.cell_idx = out_bus.cell_index;
        got.value    = out_bus.cell_value;
        got.status   = status_t'(out_bus.status);
        got.last     = out_bus.last;
        if (pending_cells.size() == 0) begin
          report_mismatch("result with nothing pending, cell", got.cell_idx, 0);
        end else begin
          want = pending_cells.pop_front();
          if (got.cell_idx != want.cell_idx) begin
            report_mismatch("cell_index", got.cell_idx, want.cell_idx);
          end
          if (got.value != want.value) report_mismatch("cell_value", got.value, want.value);
          if (got.status != want.status) report_mismatch("status", got.status, want.status);
          if (got.last != want.last) report_mismatch("last", got.last, want.last);
        end
        results_checked++;
      end
      if (in_bus.valid && in_bus.ready) begin
        if (offer_typed) pending_cells.push_back(offer_res);
        else unpack_frame(in_bus.kind, in_bus.frame_data, in_bus.frame_length);
        frames_sent++;
        if (in_bus.frame_length != LEN_OK ||
            (in_bus.kind == KIND_FULL && in_bus.frame_data[63:60] >= SEQ_COUNT)) begin
          rejected_frames++;
        end else if (in_bus.kind == KIND_FULL) begin
          full_frames++;
        end else begin
          top_frames++;
        end
      end
    end
  end

  // Watchdog: a stretch with no request taken on either side ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no request taken for %0d cycles, %0d results pending",
               quiet_cycles, pending_cells.size());
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    frame_row_t row;
    clk                 = 1'b0;
    rst_n               = 1'b0;
    in_bus.valid        = 1'b0;
    in_bus.kind         = KIND_FULL;
    in_bus.frame_data   = '0;
    in_bus.frame_length = '0;
    out_bus.ready       = 1'b0;
    offer_typed         = 1'b0;
    offer_res           = NO_RESULT;
    hold_go             = 1'b0;
    tx_idle_pct         = 34;
    rx_idle_pct         = 73;
    quiet_cycles        = 0;
    mismatches          = 0;
    frames_sent         = 0;
    full_frames         = 0;
    top_frames          = 0;
    rejected_frames     = 0;
    results_checked     = 0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table, run under the first idle mix.
    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      row = DIRECTED_ROWS[i];
      send_frame(row.kind, row.data, row.len, row.typed, row.res);
    end

    // Sender idles lightly while the receiver stalls heavily, then the
    // reverse, then full speed on both sides.
    run_random_phase(34, 73);
    run_random_phase(73, 34);
    // The long hold starts at the next edge; frames keep coming behind it.
    hold_go <= 1'b1;
    run_random_phase(0, 0);

    in_bus.valid <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk);
    // Let a stray extra result show up before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_cells.size() != 0) report_mismatch("results left pending", pending_cells.size(), 0);

    $display("run covered %0d frame requests: %0d full, %0d top-ten, %0d rejected",
             frames_sent, full_frames, top_frames, rejected_frames);
    $display("%0d cell results checked over three idle mixes and one %0d-cycle receiver hold",
             results_checked, LONG_HOLD);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
